// File: design/wpe_pkg.sv
// shared constants, tables and field widths of the wave phase estimator
package wpe_pkg;

    // field widths of input and result words
    localparam int SUM_W    = 32;
    localparam int OFF_W    = 16;
    localparam int PHASE_W  = 19;
    localparam int SUB_W    = 9;
    localparam int END_W    = 19;
    localparam int IN_DW    = 80;
    localparam int OUT_DW   = 48;

    // wave length register
    localparam int                LEN_W    = 11;
    localparam logic [LEN_W-1:0]  WL_MIN   = 11'd2;
    localparam logic [LEN_W-1:0]  WL_MAX   = 11'd1024;
    localparam logic [LEN_W-1:0]  WL_RESET = 11'd32;

    // cordic datapath: angles in 2^-32 turn
    localparam int ANG_W     = 34;
    localparam int XY_W      = 59;
    localparam int PRESCALE  = 24;
    localparam int TABLE_LEN = 24;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// File: design/wpe_cordic.sv
// pipelined vectoring cordic: angle of (sine_sum, -cosine_sum), one step per stage
module wpe_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [wpe_pkg::SUM_W-1:0]        i_sine,
    input  logic signed [wpe_pkg::SUM_W-1:0]        i_cosine,
    input  logic signed [wpe_pkg::OFF_W-1:0]        i_off,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [wpe_pkg::ANG_W-1:0]        o_ang,
    output logic signed [wpe_pkg::OFF_W-1:0]        o_off
);
    import wpe_pkg::*;

    localparam int S = CORDIC_STEPS;

    logic [S+1:0] r_v;
    logic [S+1:0] w_adv;

    logic signed [XY_W-1:0]  r_x   [0:S];
    logic signed [XY_W-1:0]  r_y   [0:S];
    logic signed [ANG_W-1:0] r_a   [0:S];
    logic                    r_yp  [0:S];
    logic                    r_yn  [0:S];
    logic signed [OFF_W-1:0] r_off [0:S];
    logic signed [ANG_W-1:0] r_ang;
    logic signed [OFF_W-1:0] r_off_o;

    logic signed [XY_W-1:0]  n_x   [0:S];
    logic signed [XY_W-1:0]  n_y   [0:S];
    logic signed [ANG_W-1:0] n_a   [0:S];
    logic signed [ANG_W-1:0] n_ang;

    // stall chain: a stage moves when empty or when the next one moves
    assign w_adv[S+1] = !r_v[S+1] || i_ready;
    genvar k;
    generate
        for (k = 0; k <= S; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate

    assign o_ready = w_adv[0];
    assign o_valid = r_v[S+1];
    assign o_ang   = r_ang;
    assign o_off   = r_off_o;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j <= S + 1; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[j-1];
                end
            end
        end
    end

    // entry: pre-rotate into the right half plane and prescale
    logic signed [SUM_W:0] w_x33, w_y33, w_nx, w_ny;
    logic signed [ANG_W-1:0] w_a0;
    always_comb begin
        w_x33 = {i_sine[SUM_W-1], i_sine};
        w_y33 = -{i_cosine[SUM_W-1], i_cosine};
        w_nx  = w_x33;
        w_ny  = w_y33;
        w_a0  = '0;
        if (w_y33 == '0) begin
            // on the x axis: no rotation, angle fixed by the sign of x
            w_nx = '0;
            w_ny = '0;
            w_a0 = w_x33[SUM_W] ? HALF_TURN : '0;
        end else if (w_x33[SUM_W]) begin
            if (w_y33 > 0) begin
                w_nx = w_y33;
                w_ny = -w_x33;
                w_a0 = QUARTER_TURN;
            end else begin
                w_nx = -w_y33;
                w_ny = w_x33;
                w_a0 = -QUARTER_TURN;
            end
        end
        n_x[0] = XY_W'(w_nx) <<< PRESCALE;
        n_y[0] = XY_W'(w_ny) <<< PRESCALE;
        n_a[0] = w_a0;
    end

    // micro-rotations, one per stage
    always_comb begin
        logic signed [XY_W-1:0] dx, dy;
        for (int i = 0; i < S; i++) begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            if (!r_yp[i] && !r_yn[i]) begin
                // on the x axis: angle is already final
                n_x[i+1] = r_x[i];
                n_y[i+1] = r_y[i];
                n_a[i+1] = r_a[i];
            end else if (r_y[i] > 0) begin
                n_x[i+1] = r_x[i] + dx;
                n_y[i+1] = r_y[i] - dy;
                n_a[i+1] = r_a[i] + $signed({2'b00, ATAN_TURNS[i]});
            end else begin
                n_x[i+1] = r_x[i] - dx;
                n_y[i+1] = r_y[i] + dy;
                n_a[i+1] = r_a[i] - $signed({2'b00, ATAN_TURNS[i]});
            end
        end
    end

    // clamp to the half plane of the original y
    always_comb begin
        n_ang = r_a[S];
        if (r_yp[S]) begin
            if (r_a[S] < 0) n_ang = '0;
            if (r_a[S] > HALF_TURN) n_ang = HALF_TURN;
        end else if (r_yn[S]) begin
            if (r_a[S] > 0) n_ang = '0;
            if (r_a[S] < -HALF_TURN) n_ang = -HALF_TURN;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= S; j++) begin
            if (w_adv[j]) begin
                r_x[j] <= n_x[j];
                r_y[j] <= n_y[j];
                r_a[j] <= n_a[j];
                if (j == 0) begin
                    r_yp[j]  <= (w_y33 > 0);
                    r_yn[j]  <= w_y33[SUM_W];
                    r_off[j] <= i_off;
                end else begin
                    r_yp[j]  <= r_yp[j-1];
                    r_yn[j]  <= r_yn[j-1];
                    r_off[j] <= r_off[j-1];
                end
            end
        end
        if (w_adv[S+1]) begin
            r_ang   <= n_ang;
            r_off_o <= r_off[S];
        end
    end

endmodule

// File: design/wpe_rem.sv
// pipelined signed remainder of acc by len << (frac-1), one quotient bit per stage
module wpe_rem #(
    parameter int ACC_W  = 25,
    parameter int FRAC   = 8,
    parameter int SIDE_W = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wpe_pkg::LEN_W-1:0]       i_len,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ACC_W-1:0]         i_acc,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [ACC_W-1:0]         o_rem,
    output logic [SIDE_W-1:0]               o_side
);
    import wpe_pkg::*;

    localparam int DN    = ACC_W - FRAC + 1;
    localparam int LOW_W = FRAC - 1;
    localparam int RW    = LEN_W;

    logic [DN+1:0] r_v;
    logic [DN+1:0] w_adv;

    logic [DN-1:0]     r_d    [0:DN];
    logic [RW-1:0]     r_rem  [0:DN];
    logic [LOW_W-1:0]  r_low  [0:DN];
    logic              r_sgn  [0:DN];
    logic [SIDE_W-1:0] r_side [0:DN];
    logic signed [ACC_W-1:0] r_out;
    logic [SIDE_W-1:0]       r_side_o;

    logic [DN-1:0]     n_d    [0:DN];
    logic [RW-1:0]     n_rem  [0:DN];
    logic [ACC_W-1:0]  w_mag;
    logic signed [ACC_W-1:0] n_out;

    assign w_adv[DN+1] = !r_v[DN+1] || i_ready;
    genvar k;
    generate
        for (k = 0; k <= DN; k++) begin : g_adv
            assign w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    endgenerate

    assign o_ready = w_adv[0];
    assign o_valid = r_v[DN+1];
    assign o_rem   = r_out;
    assign o_side  = r_side_o;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j <= DN + 1; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[j-1];
                end
            end
        end
    end

    // magnitude split: upper part divided by len, lower bits pass through
    always_comb begin
        w_mag  = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
        n_d[0] = w_mag[ACC_W-1:LOW_W];
        n_rem[0] = '0;
    end

    // restoring steps
    always_comb begin
        logic [RW:0] t;
        for (int i = 0; i < DN; i++) begin
            t = {r_rem[i], r_d[i][DN-1]};
            if (t >= {1'b0, i_len}) begin
                n_rem[i+1] = RW'(t - {1'b0, i_len});
            end else begin
                n_rem[i+1] = RW'(t);
            end
            n_d[i+1] = r_d[i] << 1;
        end
    end

    // reassemble and restore the dividend's sign
    always_comb begin
        logic [RW+LOW_W-1:0] m;
        m = {r_rem[DN], r_low[DN]};
        n_out = r_sgn[DN] ? -ACC_W'(m) : ACC_W'(m);
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= DN; j++) begin
            if (w_adv[j]) begin
                r_d[j]   <= n_d[j];
                r_rem[j] <= n_rem[j];
                if (j == 0) begin
                    r_low[j]  <= w_mag[LOW_W-1:0];
                    r_sgn[j]  <= i_acc[ACC_W-1];
                    r_side[j] <= i_side;
                end else begin
                    r_low[j]  <= r_low[j-1];
                    r_sgn[j]  <= r_sgn[j-1];
                    r_side[j] <= r_side[j-1];
                end
            end
        end
        if (w_adv[DN+1]) begin
            r_out    <= n_out;
            r_side_o <= r_side[DN];
        end
    end

endmodule

// File: design/wave_phase_estimator_unit.sv
// top level: cordic phase, sub-sample phase and nearest wave end per window
// throughput: one word per cycle unless the output stalls; every stage is a register with its own valid bit
// a stage holds while the next one is full and stalled, bubbles close up
// reset: synchronous active low, clears all valid bits and sets wave_length to 32
module wave_phase_estimator_unit #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wpe_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sine_sum [31:0], cosine_sum [63:32], window_offset [79:64]
    input  logic [wpe_pkg::IN_DW-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // phase_samples [18:0], sub_sample_phase [27:19], nearest_wave_end [46:28], zero [47]
    output logic [wpe_pkg::OUT_DW-1:0]      m_axis_tdata
);
    import wpe_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int SH     = 32 - F;
    localparam int PROD_W = ANG_W + LEN_W + 1;
    localparam int P_W    = F + 11;
    localparam int ACC_W  = F + 17;
    localparam int SW_W   = F + 1;
    localparam int E_W    = F + 11;
    localparam int SIDE_W = P_W + SW_W;
    localparam logic signed [PROD_W-1:0] RND  = PROD_W'(1) <<< (SH - 1);
    localparam logic [F-1:0]             HALF = F'(1) << (F - 1);

    // wave length register, held clamped
    logic [LEN_W-1:0] r_len;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= WL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata < WL_MIN) r_len <= WL_MIN;
            else if (i_cfg_wdata > WL_MAX) r_len <= WL_MAX;
            else r_len <= i_cfg_wdata;
        end
    end

    logic signed [LEN_W:0] w_len_s;
    assign w_len_s = $signed({1'b0, r_len});

    // cordic angle
    logic                    c_valid, c_ready;
    logic signed [ANG_W-1:0] c_ang;
    logic signed [OFF_W-1:0] c_off;

    wpe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sine   ($signed(s_axis_tdata[31:0])),
        .i_cosine ($signed(s_axis_tdata[63:32])),
        .i_off    ($signed(s_axis_tdata[79:64])),
        .o_valid  (c_valid),
        .i_ready  (c_ready),
        .o_ang    (c_ang),
        .o_off    (c_off)
    );

    // stall chain for the scaling stages
    logic r_vm, r_vp, r_va, r_vo;
    logic w_adv_m, w_adv_p, w_adv_a, w_adv_o;
    logic d_ready, d_valid;

    assign w_adv_o = !r_vo || m_axis_tready;
    assign w_adv_a = !r_va || d_ready;
    assign w_adv_p = !r_vp || w_adv_a;
    assign w_adv_m = !r_vm || w_adv_p;
    assign c_ready = w_adv_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vp <= 1'b0;
            r_va <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_adv_m) r_vm <= c_valid;
            if (w_adv_p) r_vp <= r_vm;
            if (w_adv_a) r_va <= r_vp;
            if (w_adv_o) r_vo <= d_valid;
        end
    end

    // angle times wave length
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OFF_W-1:0]  r_m_off;
    always_ff @(posedge i_clk) begin
        if (w_adv_m) begin
            r_prod  <= c_ang * w_len_s;
            r_m_off <= c_off;
        end
    end

    // round to phase in samples, wrap the fraction
    logic signed [PROD_W-1:0] w_pfull;
    logic [F-1:0]             w_frac;
    logic signed [P_W-1:0]    r_p;
    logic signed [SW_W-1:0]   r_sub;
    logic signed [OFF_W-1:0]  r_p_off;
    always_comb begin
        w_pfull = (r_prod + RND) >>> SH;
        w_frac  = w_pfull[F-1:0] + HALF;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv_p) begin
            r_p     <= w_pfull[P_W-1:0];
            r_sub   <= $signed({1'b0, w_frac}) - $signed({1'b0, HALF});
            r_p_off <= r_m_off;
        end
    end

    // dividend for the nearest wave end
    logic signed [ACC_W-1:0] w_quarter_a, r_acc;
    logic [SIDE_W-1:0]       r_a_side;
    assign w_quarter_a = ACC_W'(w_len_s) <<< (F - 2);
    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_acc    <= (ACC_W'(r_p_off) <<< F) + w_quarter_a - ACC_W'(r_p)
                        + (ACC_W'(w_len_s) <<< F);
            r_a_side <= {r_p, r_sub};
        end
    end

    // remainder by half a wave
    logic signed [ACC_W-1:0] d_rem;
    logic [SIDE_W-1:0]       d_side;
    wpe_rem #(.ACC_W(ACC_W), .FRAC(F), .SIDE_W(SIDE_W)) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len   (r_len),
        .i_valid (r_va),
        .o_ready (d_ready),
        .i_acc   (r_acc),
        .i_side  (r_a_side),
        .o_valid (d_valid),
        .i_ready (w_adv_o),
        .o_rem   (d_rem),
        .o_side  (d_side)
    );

    // output word register
    logic signed [E_W-1:0]   w_end;
    logic signed [P_W-1:0]   w_p_o;
    logic signed [SW_W-1:0]  w_sub_o;
    logic [OUT_DW-1:0]       r_out;
    always_comb begin
        w_p_o   = $signed(d_side[SIDE_W-1:SW_W]);
        w_sub_o = $signed(d_side[SW_W-1:0]);
        w_end   = (E_W'(w_len_s) <<< (F - 2)) - E_W'(d_rem);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv_o) begin
            r_out <= {1'b0, END_W'(w_end), SUB_W'(w_sub_o), PHASE_W'(w_p_o)};
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench of the wave phase estimator unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wpe_pkg::*;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 8;
    localparam int LATENCY       = CORDIC_STEPS + 26;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int HOLD_CYCLES   = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [LEN_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // sine_sum [31:0], cosine_sum [63:32], window_offset [79:64]
    logic [IN_DW-1:0]     s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // phase_samples [18:0], sub_sample_phase [27:19], nearest_wave_end [46:28], zero [47]
    logic [OUT_DW-1:0]    m_axis_tdata;

    logic [OUT_DW-1:0]    phase_words_due [$];
    logic [LEN_W-1:0]     wave_len_now = WL_RESET;
    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    bit                   idling_on = 1'b1;
    bit                   hold_request = 1'b0;

    wave_phase_estimator_unit #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // angle of (x, y) in 2^-32 turn by shift-add rotation
    function automatic longint cordic_turns(longint x, longint y);
        longint ang, nx, ny, dx, dy;
        ang = 0;
        if (y == 0) return (x < 0) ? 64'sd2147483648 : 64'sd0;
        if (x < 0) begin
            if (y > 0) begin
                nx = y; ny = -x; ang = 64'sd1073741824;
            end else begin
                nx = -y; ny = x; ang = -64'sd1073741824;
            end
            x = nx; y = ny;
        end
        x = x <<< PRESCALE;
        y = y <<< PRESCALE;
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; ang += longint'(ATAN_TURNS[i]);
            end else begin
                x -= dx; y += dy; ang -= longint'(ATAN_TURNS[i]);
            end
        end
        return ang;
    endfunction

    // expected result word for one window
    function automatic logic [OUT_DW-1:0] phase_result(logic [IN_DW-1:0] d,
                                                       logic [LEN_W-1:0] wl);
        longint s, y, off, len, ang, p, one, sub, quarter, lhalf, acc, rem, wend;
        logic [63:0] pv, sv, ev;
        s   = longint'($signed(d[31:0]));
        y   = -longint'($signed(d[63:32]));
        off = longint'($signed(d[79:64]));
        len = longint'(wl);
        if (len < 2) len = 2;
        if (len > 1024) len = 1024;
        ang = cordic_turns(s, y);
        if (y > 0) begin
            if (ang < 0) ang = 0;
            if (ang > 64'sd2147483648) ang = 64'sd2147483648;
        end else if (y < 0) begin
            if (ang > 0) ang = 0;
            if (ang < -64'sd2147483648) ang = -64'sd2147483648;
        end
        p = (ang * len + (64'sd1 <<< (31 - FRACTION_BITS))) >>> (32 - FRACTION_BITS);
        one = 64'sd1 <<< FRACTION_BITS;
        sub = ((p + (one >>> 1)) & (one - 1)) - (one >>> 1);
        quarter = len * (64'sd1 <<< (FRACTION_BITS - 2));
        lhalf = len * (64'sd1 <<< (FRACTION_BITS - 1));
        acc = off * one + quarter - p + len * one;
        rem = acc % lhalf;
        wend = quarter - rem;
        pv = p; sv = sub; ev = wend;
        return {1'b0, ev[END_W-1:0], sv[SUB_W-1:0], pv[PHASE_W-1:0]};
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        fail_count++;
        $display("mismatch %s: got %0d expected %0d", field, got, want);
    endtask

    // predict on input acceptance, check on output acceptance, watchdog
    always @(posedge i_clk) begin
        logic [OUT_DW-1:0] want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            phase_words_due.push_back(phase_result(s_axis_tdata, wave_len_now));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (phase_words_due.size() == 0) begin
                report_mismatch("unexpected word", longint'(m_axis_tdata), 0);
            end else begin
                want = phase_words_due.pop_front();
                if (m_axis_tdata[18:0] !== want[18:0])
                    report_mismatch("phase_samples", $signed(m_axis_tdata[18:0]),
                                    $signed(want[18:0]));
                if (m_axis_tdata[27:19] !== want[27:19])
                    report_mismatch("sub_sample_phase", $signed(m_axis_tdata[27:19]),
                                    $signed(want[27:19]));
                if (m_axis_tdata[46:28] !== want[46:28])
                    report_mismatch("nearest_wave_end", $signed(m_axis_tdata[46:28]),
                                    $signed(want[46:28]));
                if (m_axis_tdata[47] !== want[47])
                    report_mismatch("pad bit", m_axis_tdata[47], 0);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts and an on-demand long hold-off
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int stall_left = 0;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idling_on && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    // offer one word, with an optional idle burst in front of it
    task automatic send_window(logic [31:0] sine, logic [31:0] cosine, logic [15:0] off);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off, cosine, sine};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid, wait for all results, then let the pipeline empty
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (phase_words_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_wave_length(logic [LEN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        wave_len_now = value;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sum();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom() >>> $urandom_range(0, 31);
            default: return $urandom_range(0, 1) ? 32'h0
                                                 : {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0};
        endcase
    endfunction

    task automatic random_window();
        logic [31:0] sv, cv;
        logic [15:0] ov;
        sv = random_sum();
        cv = random_sum();
        ov = $urandom();
        send_window(sv, cv, ov);
    endtask

    // extremes of the sums and offset, zero sums, zero cosine both signs
    task automatic test_directed();
        logic [31:0] edges [6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h0000_0400};
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 4; j++)
                send_window(edges[i], edges[(i + j) % 6],
                            (j == 0) ? 16'h7FFF : (j == 1) ? 16'h8000 : 16'(i * 37));
        drain_pipe();
    endtask

    // wave length extremes, out-of-range values and odd lengths
    task automatic test_wave_lengths();
        logic [LEN_W-1:0] lens [8] = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd1025,
                                       11'd2047, 11'd3, 11'd777};
        foreach (lens[k]) begin
            write_wave_length(lens[k]);
            send_window(32'h0, 32'h0, 16'h8000);
            send_window(32'hFFFF_FFF0, 32'h0, 16'h7FFF);
            send_window(32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
            repeat (12) random_window();
            drain_pipe();
        end
    endtask

    // random windows under several register settings
    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 0) begin
                drain_pipe();
                write_wave_length((n % 600 == 0) ? 11'($urandom_range(2, 64))
                                                 : 11'($urandom_range(0, 2047)));
            end
            random_window();
        end
        drain_pipe();
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (120) random_window();
        drain_pipe();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_wave_lengths();
        test_backpressure();
        test_random(1150);
        // final stretch with no idling on either side
        idling_on = 1'b0;
        test_random(300);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
